// File: src/phnl_pkg.sv
package phnl_pkg;

  // Fixed field widths of the request and result channels
  localparam int CMD_W      = 3;
  localparam int ENTRY_W    = 8;
  localparam int POS_W      = 5;
  localparam int VALUE_W    = 16;
  localparam int CHAR_W     = 8;
  localparam int SLOT_OUT_W = 8;
  localparam int REG_W      = 9;
  localparam int REG_IDX_W  = 1;

  // Displacement entries and weighted sums
  localparam int DISP_W = 16;
  localparam int SUM_W  = 32;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam cmd_t CMD_WEIGHT1 = 3'd0;
  localparam cmd_t CMD_WEIGHT2 = 3'd1;
  localparam cmd_t CMD_DISP    = 3'd2;
  localparam cmd_t CMD_KEY_CHR = 3'd3;
  localparam cmd_t CMD_KEY_LEN = 3'd4;
  localparam cmd_t CMD_LOOKUP  = 3'd5;

  localparam reg_idx_t REG_G_ENTRIES = 1'b0;
  localparam reg_idx_t REG_SLOTS     = 1'b1;

endpackage

// File: src/perfect_hash_name_lookup_core.sv
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  -----------------------------------------------
// request   in         req_valid/req_stall  command entry_index char_position value
//                                           last_char empty_name
// result    out        rsp_valid/rsp_stall  found slot too_long
// config    in         cfg_we               cfg_index cfg_data
//
// Table writes are taken in idle. For a lookup character the weight memories
// are read at the accept edge, the products are summed next. The closing
// request of a name runs two passes of the bit-serial remainder unit (one
// dividend bit a cycle), two displacement reads over a single port, a key
// length check and a key walk through the key memory, character by character.
// A too-long name skips the remainder passes and goes from S_FIN to S_OUT.
// Reset is synchronous and clears only control state; the table memories hold
// garbage until loaded. While a result waits under rsp_stall the block still
// takes requests in idle; it stalls whenever its sequencer is not idle, and
// holds in S_OUT when a second result is ready before the first has left.
module perfect_hash_name_lookup_core
  import phnl_pkg::*;
#(
  parameter int MAX_KEY_LEN = 32,
  parameter int G_DEPTH     = 256,
  parameter int SLOT_COUNT  = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  cmd_t                  command,
  input  logic [ENTRY_W-1:0]    entry_index,
  input  logic [POS_W-1:0]      char_position,
  input  logic [VALUE_W-1:0]    value,
  input  logic                  last_char,
  input  logic                  empty_name,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  found,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic                  too_long,
  input  logic                  cfg_we,
  input  reg_idx_t              cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  // Derived widths
  localparam int LI_W     = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int NL_W     = $clog2(MAX_KEY_LEN + 1);
  localparam int KL_W     = $clog2(MAX_KEY_LEN + 2);
  localparam int GA_W     = $clog2(G_DEPTH);
  localparam int SA_W     = $clog2(SLOT_COUNT);
  localparam int KC_DEPTH = SLOT_COUNT * MAX_KEY_LEN;
  localparam int KC_AW    = $clog2(KC_DEPTH);
  localparam int DVW      = $clog2(((G_DEPTH > SLOT_COUNT) ? G_DEPTH : SLOT_COUNT) + 1);
  localparam int PROD_W   = WEIGHT_BITS + CHAR_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_FIN   = 4'd2;
  localparam logic [3:0] S_DIV1  = 4'd3;
  localparam logic [3:0] S_GRD_U = 4'd4;
  localparam logic [3:0] S_GRD_V = 4'd5;
  localparam logic [3:0] S_GSUM  = 4'd6;
  localparam logic [3:0] S_DIV2  = 4'd7;
  localparam logic [3:0] S_KLEN  = 4'd8;
  localparam logic [3:0] S_KCHK  = 4'd9;
  localparam logic [3:0] S_WRD   = 4'd10;
  localparam logic [3:0] S_WCMP  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // Table memories
  logic [WEIGHT_BITS-1:0] w1_mem  [MAX_KEY_LEN];
  logic [WEIGHT_BITS-1:0] w2_mem  [MAX_KEY_LEN];
  logic [DISP_W-1:0]      disp_mem[G_DEPTH];
  logic [CHAR_W-1:0]      kc_mem  [KC_DEPTH];
  logic [KL_W-1:0]        kl_mem  [SLOT_COUNT];
  logic [CHAR_W-1:0]      nb_mem  [MAX_KEY_LEN];

  // Registered read data
  logic [WEIGHT_BITS-1:0] w1_rd;
  logic [WEIGHT_BITS-1:0] w2_rd;
  logic [DISP_W-1:0]      disp_rd;
  logic [CHAR_W-1:0]      kc_rd;
  logic [KL_W-1:0]        kl_rd;
  logic [CHAR_W-1:0]      nb_rd;

  // Control and name state
  logic [3:0]        state;
  logic [REG_W-1:0]  g_entries_in_use;
  logic [REG_W-1:0]  slots_in_use;
  logic [NL_W-1:0]   name_length;
  logic [SUM_W-1:0]  first_sum;
  logic [SUM_W-1:0]  second_sum;
  logic              name_overflow;
  logic [CHAR_W-1:0] char_reg;
  logic              last_reg;
  logic [GA_W-1:0]   u_reg;
  logic [GA_W-1:0]   v_reg;
  logic [DISP_W-1:0] g_u;
  logic [SA_W-1:0]   slot_reg;
  logic [NL_W-1:0]   walk_i;
  logic              found_res;
  logic              too_long_res;

  logic              req_accept;
  logic              takes_char;
  logic              name_full;
  logic [DVW-1:0]    n_clamp;
  logic [DVW-1:0]    m_clamp;
  logic [DISP_W:0]   gsum;
  logic [PROD_W-1:0] prod1;
  logic [PROD_W-1:0] prod2;
  logic [GA_W-1:0]   disp_raddr;
  logic              start_a;
  logic              start_b;
  logic [SUM_W-1:0]  dividend_a;
  logic [DVW-1:0]    divisor_a;
  logic              done_a;
  logic              done_b;
  logic [DVW-1:0]    rem_a;
  logic [DVW-1:0]    rem_b;

  function automatic logic [KC_AW-1:0] kc_addr(input logic [SA_W-1:0] s,
                                               input logic [LI_W-1:0] p);
    return KC_AW'(s) * KC_AW'(MAX_KEY_LEN) + KC_AW'(p);
  endfunction

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign takes_char = !(last_char && empty_name);
  assign name_full  = (name_length == NL_W'(MAX_KEY_LEN));

  // Moduli: zero counts as one, oversize values cap at the table depth
  assign n_clamp = (g_entries_in_use == '0) ? DVW'(1) :
                   (32'(g_entries_in_use) > G_DEPTH) ? DVW'(G_DEPTH) :
                   DVW'(g_entries_in_use);
  assign m_clamp = (slots_in_use == '0) ? DVW'(1) :
                   (32'(slots_in_use) > SLOT_COUNT) ? DVW'(SLOT_COUNT) :
                   DVW'(slots_in_use);

  assign prod1 = PROD_W'(w1_rd) * PROD_W'(char_reg);
  assign prod2 = PROD_W'(w2_rd) * PROD_W'(char_reg);
  assign gsum  = {1'b0, g_u} + {1'b0, disp_rd};

  assign disp_raddr = (state == S_GRD_U) ? u_reg : v_reg;

  // Unit A reduces the first sum, then the displacement sum; unit B the second sum
  assign start_b    = (state == S_FIN) && !name_overflow;
  assign start_a    = start_b || (state == S_GSUM);
  assign dividend_a = (state == S_GSUM) ? SUM_W'(gsum) : first_sum;
  assign divisor_a  = (state == S_GSUM) ? m_clamp : n_clamp;

  phnl_mod_unit #(.DVW(DVW)) u_mod_a (
    .clk      (clk),
    .rst      (rst),
    .start    (start_a),
    .dividend (dividend_a),
    .divisor  (divisor_a),
    .done     (done_a),
    .rem      (rem_a)
  );

  phnl_mod_unit #(.DVW(DVW)) u_mod_b (
    .clk      (clk),
    .rst      (rst),
    .start    (start_b),
    .dividend (second_sum),
    .divisor  (n_clamp),
    .done     (done_b),
    .rem      (rem_b)
  );

  // Memory writes: only load requests and name characters, all in idle
  always_ff @(posedge clk) begin
    if (req_accept) begin
      unique case (command)
        CMD_WEIGHT1: begin
          if (32'(entry_index) < MAX_KEY_LEN)
            w1_mem[LI_W'(entry_index)] <= WEIGHT_BITS'(value);
        end
        CMD_WEIGHT2: begin
          if (32'(entry_index) < MAX_KEY_LEN)
            w2_mem[LI_W'(entry_index)] <= WEIGHT_BITS'(value);
        end
        CMD_DISP: begin
          if (32'(entry_index) < G_DEPTH)
            disp_mem[GA_W'(entry_index)] <= value;
        end
        CMD_KEY_CHR: begin
          if (32'(entry_index) < SLOT_COUNT && 32'(char_position) < MAX_KEY_LEN)
            kc_mem[kc_addr(SA_W'(entry_index), LI_W'(char_position))] <= value[CHAR_W-1:0];
        end
        CMD_KEY_LEN: begin
          if (32'(entry_index) < SLOT_COUNT)
            kl_mem[SA_W'(entry_index)] <= (32'(value) > MAX_KEY_LEN) ?
                                          KL_W'(MAX_KEY_LEN + 1) : KL_W'(value);
        end
        CMD_LOOKUP: begin
          if (takes_char && !name_full)
            nb_mem[name_length[LI_W-1:0]] <= value[CHAR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Memory reads, registered
  always_ff @(posedge clk) begin
    w1_rd   <= w1_mem[name_length[LI_W-1:0]];
    w2_rd   <= w2_mem[name_length[LI_W-1:0]];
    disp_rd <= disp_mem[disp_raddr];
    kl_rd   <= kl_mem[slot_reg];
    kc_rd   <= kc_mem[kc_addr(slot_reg, walk_i[LI_W-1:0])];
    nb_rd   <= nb_mem[walk_i[LI_W-1:0]];
  end

  // Sequencer and name state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      g_entries_in_use <= REG_W'(256);
      slots_in_use     <= REG_W'(256);
      name_length      <= '0;
      first_sum        <= '0;
      second_sum       <= '0;
      name_overflow    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_G_ENTRIES: g_entries_in_use <= cfg_data;
          REG_SLOTS:     slots_in_use     <= cfg_data;
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req_accept && command == CMD_LOOKUP) begin
            if (takes_char && !name_full) begin
              state <= S_ACC;
            end else begin
              // Drop characters past the key length limit, remember the overflow
              if (takes_char) name_overflow <= 1'b1;
              if (last_char) state <= S_FIN;
            end
          end
        end
        S_ACC: begin
          first_sum   <= first_sum + SUM_W'(prod1);
          second_sum  <= second_sum + SUM_W'(prod2);
          name_length <= name_length + 1'b1;
          state       <= last_reg ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          state <= name_overflow ? S_OUT : S_DIV1;
        end
        S_DIV1: begin
          if (done_a) state <= S_GRD_U;
        end
        S_GRD_U: state <= S_GRD_V;
        S_GRD_V: state <= S_GSUM;
        S_GSUM:  state <= S_DIV2;
        S_DIV2: begin
          if (done_a) state <= S_KLEN;
        end
        S_KLEN: state <= S_KCHK;
        S_KCHK: begin
          if (kl_rd != KL_W'(name_length) || name_length == '0) state <= S_OUT;
          else state <= S_WRD;
        end
        S_WRD: state <= S_WCMP;
        S_WCMP: begin
          if (kc_rd != nb_rd || walk_i == name_length - 1'b1) state <= S_OUT;
          else state <= S_WRD;
        end
        S_OUT: begin
          // Hold until the result register is free, then reset the name
          if (!rsp_valid || !rsp_stall) begin
            state         <= S_IDLE;
            name_length   <= '0;
            first_sum     <= '0;
            second_sum    <= '0;
            name_overflow <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the lookup
  always_ff @(posedge clk) begin
    if (req_accept) begin
      char_reg <= value[CHAR_W-1:0];
      last_reg <= last_char;
    end
    if (state == S_FIN) begin
      too_long_res <= name_overflow;
      found_res    <= 1'b0;
      slot_reg     <= '0;
    end
    if (state == S_DIV1 && done_a) begin
      u_reg <= GA_W'(rem_a);
      v_reg <= GA_W'(rem_b);
    end
    if (state == S_GRD_V) g_u <= disp_rd;
    if (state == S_DIV2 && done_a) slot_reg <= SA_W'(rem_a);
    if (state == S_KCHK) begin
      walk_i    <= '0;
      found_res <= (kl_rd == KL_W'(name_length)) && (name_length == '0);
    end
    if (state == S_WCMP) begin
      walk_i    <= walk_i + 1'b1;
      found_res <= (kc_rd == nb_rd) && (walk_i == name_length - 1'b1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
      found    <= found_res;
      too_long <= too_long_res;
      slot     <= SLOT_OUT_W'(slot_reg);
    end
  end

  // A too-long name never reports a hit or a slot
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && too_long |-> !found && slot == '0)
    else $error("too-long result carries a hit or a slot");

  // The collected name never exceeds the key length limit
  assert property (@(posedge clk) disable iff (rst)
    name_length <= NL_W'(MAX_KEY_LEN))
    else $error("name length past the limit");

  // Both remainder units run in lockstep on the hash sums
  assert property (@(posedge clk) disable iff (rst)
    done_b |-> done_a && state == S_DIV1)
    else $error("remainder units out of step");

  // Character accumulation follows an accepted lookup request only
  assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |-> $past(req_accept && command == CMD_LOOKUP))
    else $error("accumulation without a lookup request");

endmodule

// File: src/phnl_mod_unit.sv
module phnl_mod_unit
  import phnl_pkg::*;
#(
  parameter int DVW = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DVW-1:0]   divisor,
  output logic             done,
  output logic [DVW-1:0]   rem
);

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] quo_sh;
  logic [DVW-1:0]   part;
  logic [DVW-1:0]   dvs;
  logic [DVW:0]     trial;
  logic [DVW:0]     diff;
  logic [DVW-1:0]   part_next;

  // Restoring remainder, one dividend bit per cycle
  assign trial = {part, quo_sh[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign part_next = (trial >= {1'b0, dvs}) ? diff[DVW-1:0] : trial[DVW-1:0];
  assign rem = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= dividend;
      part   <= '0;
      dvs    <= divisor;
    end else if (busy) begin
      quo_sh <= {quo_sh[SUM_W-2:0], 1'b0};
      part   <= part_next;
    end
  end

endmodule
